[design/array_linked_list_engine_core_macros.svh]
// Assertion macros for the array linked-list engine core.
// Included by the top level; no other dependencies.
`ifndef ARRAY_LINKED_LIST_ENGINE_CORE_MACROS_SVH
`define ARRAY_LINKED_LIST_ENGINE_CORE_MACROS_SVH
`ifndef SYNTH
`define ALLE_ASSERT_IMP(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("alle: same-cycle check failed");
`define ALLE_ASSERT_NXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("alle: next-cycle check failed");
`else
`define ALLE_ASSERT_IMP(label, clk, rst, pre, post)
`define ALLE_ASSERT_NXT(label, clk, rst, pre, post)
`endif
`endif

[design/alle_pkg.sv]
// Shared constants, codes and transfer types for the array linked-list engine.
// No dependencies.
package alle_pkg;

  localparam int NODES      = 256;
  localparam int VALUE_BITS = 32;
  localparam int IDX_W      = $clog2(NODES);
  localparam int CNT_W      = $clog2(NODES + 1);
  localparam int FIELD_W    = 8;
  localparam int DATA_W     = 32;

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic [2:0] {
    CMD_NEW_LIST   = 3'd0,
    CMD_INSERT     = 3'd1,
    CMD_DELETE     = 3'd2,
    CMD_FIND       = 3'd3,
    CMD_MAKE_EMPTY = 3'd4,
    CMD_READ_NODE  = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_NO_SPACE  = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e                command;
    logic [FIELD_W-1:0]  list_head;
    logic [FIELD_W-1:0]  position;
    logic signed [DATA_W-1:0] value;
  } request_t;

  typedef struct packed {
    status_e             status;
    logic [FIELD_W-1:0]  slot;
    logic signed [DATA_W-1:0] slot_value;
    logic [FIELD_W-1:0]  slot_next;
  } result_t;

  typedef struct packed {
    logic we;
    idx_t waddr;
    idx_t wdata;
    idx_t raddr;
  } link_port_t;

  typedef struct packed {
    logic   we;
    idx_t   waddr;
    value_t wdata;
    idx_t   raddr;
  } value_port_t;

endpackage

[design/alle_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// Read returns the old data on a same-address write. No dependencies.
module alle_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/alle_ctrl.sv]
// Command sequencer of the linked-list engine: init sweep, allocation,
// chain walks and result register. Depends on alle_pkg.
module alle_ctrl import alle_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  request_t    request,
  output logic        busy,
  output logic        done,
  output result_t     result,
  output link_port_t  link_port,
  output value_port_t value_port,
  input  idx_t        link_rdata,
  input  value_t      value_rdata
);

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_ALLOC_RD,
    S_ALLOC_LINK,
    S_NEW_FIN,
    S_INS_LINK,
    S_INS_FIN,
    S_WALK_FIRST,
    S_WALK,
    S_DEL_FREE,
    S_DEL_FIN,
    S_EMPTY_HEAD,
    S_EMPTY_WALK,
    S_EMPTY_FIN,
    S_READ,
    S_NOP
  } state_t;

  state_t state;
  cmd_e   cmd;
  idx_t   head;
  idx_t   pos;
  value_t key;
  idx_t   t;
  idx_t   p;
  idx_t   prev;
  idx_t   hold;
  cnt_t   n;

  idx_t   head_in;
  idx_t   pos_in;
  logic   match;
  cnt_t   n_inc;
  logic   walk_go;

  function automatic result_t make_result(status_e st, idx_t s, value_t v, idx_t nx);
    result_t r;
    r.status     = st;
    r.slot       = FIELD_W'(s);
    r.slot_value = DATA_W'(v);
    r.slot_next  = FIELD_W'(nx);
    return r;
  endfunction

  assign head_in = idx_t'(request.list_head);
  assign pos_in  = idx_t'(request.position);
  assign match   = (value_rdata == key);
  assign n_inc   = n + cnt_t'(1);
  assign walk_go = (link_rdata != '0) && (n != cnt_t'(NODES));
  assign busy    = (state != S_IDLE);

  always_comb begin
    link_port  = '0;
    value_port = '0;
    case (state)
      S_INIT: begin
        link_port.we    = 1'b1;
        link_port.waddr = n[IDX_W-1:0];
        link_port.wdata = (n == cnt_t'(NODES - 1)) ? '0 : n_inc[IDX_W-1:0];
      end
      S_IDLE: begin
        value_port.raddr = pos_in;
        case (request.command)
          CMD_DELETE, CMD_FIND: link_port.raddr = head_in;
          CMD_READ_NODE:        link_port.raddr = pos_in;
          default:              link_port.raddr = '0;
        endcase
      end
      S_ALLOC_RD: begin
        link_port.raddr = link_rdata;
      end
      S_ALLOC_LINK: begin
        link_port.we    = 1'b1;
        link_port.waddr = '0;
        link_port.wdata = link_rdata;
        link_port.raddr = pos;
      end
      S_NEW_FIN: begin
        link_port.we    = 1'b1;
        link_port.waddr = t;
        link_port.wdata = '0;
      end
      S_INS_LINK: begin
        link_port.we     = 1'b1;
        link_port.waddr  = t;
        link_port.wdata  = (pos == '0) ? hold : link_rdata;
        value_port.we    = 1'b1;
        value_port.waddr = t;
        value_port.wdata = key;
      end
      S_INS_FIN: begin
        link_port.we    = 1'b1;
        link_port.waddr = pos;
        link_port.wdata = t;
      end
      S_WALK_FIRST: begin
        link_port.raddr  = link_rdata;
        value_port.raddr = link_rdata;
      end
      S_WALK: begin
        if (match && (cmd == CMD_DELETE)) begin
          link_port.we    = 1'b1;
          link_port.waddr = prev;
          link_port.wdata = link_rdata;
          link_port.raddr = '0;
        end else begin
          link_port.raddr  = link_rdata;
          value_port.raddr = link_rdata;
        end
      end
      S_DEL_FREE: begin
        link_port.we    = 1'b1;
        link_port.waddr = p;
        link_port.wdata = (prev == '0) ? hold : link_rdata;
      end
      S_DEL_FIN: begin
        link_port.we    = 1'b1;
        link_port.waddr = '0;
        link_port.wdata = p;
      end
      S_EMPTY_HEAD: begin
        link_port.raddr = head;
      end
      S_EMPTY_WALK: begin
        link_port.we    = 1'b1;
        link_port.wdata = hold;
        if (walk_go) begin
          link_port.waddr = link_rdata;
          link_port.raddr = link_rdata;
        end else begin
          link_port.waddr = '0;
        end
      end
      S_EMPTY_FIN: begin
        link_port.we    = 1'b1;
        link_port.waddr = head;
        link_port.wdata = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      n     <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_INIT: begin
          n <= n_inc;
          if (n == cnt_t'(NODES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            cmd  <= request.command;
            head <= head_in;
            pos  <= pos_in;
            key  <= value_t'(request.value);
            prev <= head_in;
            n    <= '0;
            case (request.command)
              CMD_NEW_LIST, CMD_INSERT: state <= S_ALLOC_RD;
              CMD_DELETE, CMD_FIND:     state <= S_WALK_FIRST;
              CMD_MAKE_EMPTY:           state <= S_EMPTY_HEAD;
              CMD_READ_NODE:            state <= S_READ;
              default:                  state <= S_NOP;
            endcase
          end
        end
        S_ALLOC_RD: begin
          if (link_rdata == '0) begin
            result <= make_result(ST_NO_SPACE, '0, '0, '0);
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            t     <= link_rdata;
            state <= S_ALLOC_LINK;
          end
        end
        S_ALLOC_LINK: begin
          hold  <= link_rdata;
          state <= (cmd == CMD_NEW_LIST) ? S_NEW_FIN : S_INS_LINK;
        end
        S_NEW_FIN, S_INS_FIN: begin
          result <= make_result(ST_OK, t, '0, '0);
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        S_INS_LINK: begin
          state <= S_INS_FIN;
        end
        S_WALK_FIRST: begin
          if (link_rdata == '0) begin
            result <= make_result(ST_NOT_FOUND, '0, '0, '0);
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            p     <= link_rdata;
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (match) begin
            if (cmd == CMD_FIND) begin
              result <= make_result(ST_OK, p, '0, '0);
              done   <= 1'b1;
              state  <= S_IDLE;
            end else begin
              hold  <= link_rdata;
              state <= S_DEL_FREE;
            end
          end else begin
            prev <= p;
            n    <= n_inc;
            if ((link_rdata == '0) || (n_inc == cnt_t'(NODES))) begin
              result <= make_result(ST_NOT_FOUND, '0, '0, '0);
              done   <= 1'b1;
              state  <= S_IDLE;
            end else begin
              p <= link_rdata;
            end
          end
        end
        S_DEL_FREE: begin
          state <= S_DEL_FIN;
        end
        S_DEL_FIN: begin
          result <= make_result(ST_OK, p, '0, '0);
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        S_EMPTY_HEAD: begin
          hold  <= link_rdata;
          state <= S_EMPTY_WALK;
        end
        S_EMPTY_WALK: begin
          if (walk_go) begin
            hold <= link_rdata;
            n    <= n_inc;
          end else begin
            state <= S_EMPTY_FIN;
          end
        end
        S_EMPTY_FIN: begin
          result <= make_result(ST_OK, '0, '0, '0);
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        S_READ: begin
          result <= make_result(ST_OK, pos, value_rdata, link_rdata);
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        default: begin
          result <= make_result(ST_OK, '0, '0, '0);
          done   <= 1'b1;
          state  <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[design/array_linked_list_engine_core.sv]
// Top level of the array linked-list engine: sequencer plus link and value RAMs.
// Depends on alle_pkg, alle_ram, alle_ctrl and the assertion macro header.
//
// Usage: drive request and raise start; a command transfers at the clock edge
// where start is high and busy is low. Exactly one result follows per command,
// shown on result for a single cycle with done high; the receiver cannot stall
// it and must take it in that cycle. busy stays high from the transfer until
// the cycle done rises, so one command is in flight at a time.
// Walks visit one node per cycle, at most NODES nodes per command, set by the
// registered read of the link RAM feeding the next address.
// After reset busy holds high while the link RAM is swept to chain every slot
// into the free list; no command transfers during that sweep.
// The value RAM is not cleared.
`include "array_linked_list_engine_core_macros.svh"
module array_linked_list_engine_core import alle_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  request_t request,
  output logic     busy,
  output logic     done,
  output result_t  result
);

  link_port_t  link_port;
  value_port_t value_port;
  idx_t        link_rdata;
  value_t      value_rdata;

  alle_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .request     (request),
    .busy        (busy),
    .done        (done),
    .result      (result),
    .link_port   (link_port),
    .value_port  (value_port),
    .link_rdata  (link_rdata),
    .value_rdata (value_rdata)
  );

  alle_ram #(
    .DEPTH (NODES),
    .WIDTH (IDX_W)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_port.we),
    .waddr (link_port.waddr),
    .wdata (link_port.wdata),
    .raddr (link_port.raddr),
    .rdata (link_rdata)
  );

  alle_ram #(
    .DEPTH (NODES),
    .WIDTH (VALUE_BITS)
  ) u_value_ram (
    .clk   (clk),
    .we    (value_port.we),
    .waddr (value_port.waddr),
    .wdata (value_port.wdata),
    .raddr (value_port.raddr),
    .rdata (value_rdata)
  );

  `ALLE_ASSERT_IMP(a_done_idle, clk, rst, done, !busy)
  `ALLE_ASSERT_NXT(a_busy_after_transfer, clk, rst, start && !busy, busy)
  `ALLE_ASSERT_NXT(a_done_single, clk, rst, done, !done)
  `ALLE_ASSERT_IMP(a_fail_no_slot, clk, rst, done && (result.status != ST_OK), result.slot == '0)

endmodule

[dv/array_linked_list_engine_core_tb.sv]
// Self-checking testbench for array_linked_list_engine_core: directed and random list
// commands checked against a predictor of the node store. Depends on alle_pkg and the RTL.
module array_linked_list_engine_core_tb;
  import alle_pkg::*;

  localparam int RANDOM_CMDS  = 930;
  localparam int WATCH_LIMIT  = 4 * NODES + 1000;
  localparam int CALM_TAIL    = 80;

  logic     clk;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  request_t request = '0;
  logic     busy;
  logic     done;
  result_t  result;

  idx_t   link_mem [NODES];
  value_t val_mem [NODES];
  bit     val_set [NODES];
  idx_t   list_heads [$];

  request_t cmd_backlog [$];
  result_t  backlog_results [$];
  result_t  due_results [$];

  int bad = 0;
  int sent = 0;
  int gap_left = 0;
  int quiet = 0;

  array_linked_list_engine_core u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .request(request),
    .busy(busy),
    .done(done),
    .result(result)
  );

  function automatic result_t apply_list_cmd(input request_t r, input bit commit,
                                             output bit unsafe);
    result_t res;
    idx_t h, q, p, prev, nxt, t;
    int n;
    res = '0;
    unsafe = 1'b0;
    h = r.list_head;
    q = r.position;
    case (r.command)
      CMD_NEW_LIST, CMD_INSERT: begin
        t = link_mem[0];
        if (t == 0) begin
          res.status = ST_NO_SPACE;
        end else begin
          res.slot = t;
          if (commit) begin
            link_mem[0] = link_mem[t];
            if (r.command == CMD_NEW_LIST) begin
              link_mem[t] = '0;
            end else begin
              val_mem[t] = r.value;
              val_set[t] = 1'b1;
              link_mem[t] = link_mem[q];
              link_mem[q] = t;
            end
          end
        end
      end
      CMD_DELETE, CMD_FIND: begin
        prev = h;
        p = link_mem[h];
        for (n = 0; p != 0 && n < NODES; n++) begin
          if (!val_set[p]) unsafe = 1'b1;
          if (val_mem[p] == r.value) break;
          prev = p;
          p = link_mem[p];
        end
        if (p != 0 && n < NODES) begin
          res.slot = p;
          if (commit && r.command == CMD_DELETE) begin
            link_mem[prev] = link_mem[p];
            link_mem[p] = link_mem[0];
            link_mem[0] = p;
          end
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      CMD_MAKE_EMPTY: begin
        if (commit) begin
          p = link_mem[h];
          for (n = 0; p != 0 && n < NODES; n++) begin
            nxt = link_mem[p];
            link_mem[p] = link_mem[0];
            link_mem[0] = p;
            p = nxt;
          end
          link_mem[h] = '0;
        end
      end
      CMD_READ_NODE: begin
        unsafe = !val_set[q];
        res.slot = q;
        res.slot_value = val_mem[q];
        res.slot_next = link_mem[q];
      end
      default: ;
    endcase
    return res;
  endfunction

  // Queue a command only if it never touches a value that was never written.
  function automatic bit send(input request_t r, output result_t res);
    bit unsafe;
    res = apply_list_cmd(r, 1'b0, unsafe);
    if (unsafe) return 1'b0;
    res = apply_list_cmd(r, 1'b1, unsafe);
    cmd_backlog.push_back(r);
    backlog_results.push_back(res);
    return 1'b1;
  endfunction

  function automatic idx_t order(cmd_e c, idx_t h, idx_t q, value_t v);
    request_t r;
    result_t res;
    r = '{command: c, list_head: h, position: q, value: v};
    void'(send(r, res));
    return res.slot;
  endfunction

  function automatic value_t pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return '0;
      3: return '1;
      4, 5, 6: return value_t'($urandom_range(1, 7));
      default: return value_t'($urandom);
    endcase
  endfunction

  function automatic idx_t pick_in_list(idx_t h);
    idx_t q;
    int k;
    q = h;
    k = $urandom_range(0, 6);
    repeat (k) if (link_mem[q] != 0) q = link_mem[q];
    return q;
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    request_t r;
    result_t res;
    idx_t lst, a, b, s, h;
    int sel, made;

    for (int i = 0; i < NODES; i++) begin
      link_mem[i] = (i == NODES - 1) ? idx_t'(0) : idx_t'(i + 1);
      val_mem[i] = '0;
      val_set[i] = 1'b0;
    end

    lst = order(CMD_NEW_LIST, '0, '0, '0);
    list_heads.push_back(lst);
    a = order(CMD_INSERT, '0, lst, 32'h7fff_ffff);
    b = order(CMD_INSERT, '0, a, 32'h8000_0000);
    void'(order(CMD_INSERT, '0, lst, '0));
    void'(order(CMD_INSERT, '0, lst, '1));
    void'(order(CMD_FIND, lst, '0, 32'h8000_0000));
    void'(order(CMD_FIND, lst, '0, 32'd12345));
    void'(order(CMD_DELETE, lst, '0, '0));
    void'(order(CMD_DELETE, lst, '0, 32'd999));
    void'(order(CMD_DELETE, lst, '0, 32'h8000_0000));
    void'(order(CMD_READ_NODE, '0, a, '0));
    void'(order(CMD_READ_NODE, '1, b, '1));
    void'(order(cmd_e'(3'd6), '1, '1, '1));
    void'(order(cmd_e'(3'd7), '0, '0, '0));
    void'(order(CMD_INSERT, '0, '0, 32'd1));
    // Insert after the free-list head: the new node links to itself.
    s = link_mem[0];
    void'(order(CMD_INSERT, '0, s, 32'd5));
    void'(order(CMD_FIND, s, '0, 32'd77));
    void'(order(CMD_DELETE, s, '0, 32'd77));
    void'(order(CMD_FIND, s, '0, 32'd5));
    void'(order(CMD_MAKE_EMPTY, s, '0, '0));
    void'(order(CMD_MAKE_EMPTY, lst, '0, '0));
    void'(order(CMD_INSERT, '0, '1, 32'h5a5a_5a5a));
    list_heads.push_back(order(CMD_NEW_LIST, '1, '1, '1));

    made = 0;
    while (made < RANDOM_CMDS) begin
      r = '0;
      r.value = pick_value();
      h = list_heads[$urandom_range(0, list_heads.size() - 1)];
      sel = $urandom_range(0, 99);
      if (sel < 6 && list_heads.size() < 12) begin
        r.command = CMD_NEW_LIST;
        r.list_head = FIELD_W'($urandom);
        r.position = FIELD_W'($urandom);
      end else if (sel < 40) begin
        r.command = CMD_INSERT;
        r.position = pick_in_list(h);
      end else if (sel < 55) begin
        r.command = CMD_FIND;
        r.list_head = h;
      end else if (sel < 70) begin
        r.command = CMD_DELETE;
        r.list_head = h;
      end else if (sel < 78) begin
        r.command = CMD_READ_NODE;
        r.position = pick_in_list(h);
      end else if (sel < 84) begin
        r.command = CMD_MAKE_EMPTY;
        r.list_head = h;
      end else begin
        r.command = cmd_e'($urandom_range(0, 7));
        r.list_head = FIELD_W'($urandom);
        r.position = FIELD_W'($urandom);
        r.value = $urandom;
        // Keep the free list alive for the rest of the run.
        if (r.command == CMD_MAKE_EMPTY && r.list_head == 0) r.list_head = 8'd1;
      end
      if (send(r, res)) begin
        if (r.command == CMD_NEW_LIST && res.status == ST_OK) list_heads.push_back(res.slot);
        if (r.command <= CMD_READ_NODE) made++;
      end
    end

    void'(order(CMD_MAKE_EMPTY, '0, '0, '0));
    void'(order(CMD_NEW_LIST, '0, '0, '0));
    void'(order(CMD_INSERT, '0, lst, 32'd3));
    void'(order(CMD_READ_NODE, '0, a, '0));

    while (cmd_backlog.size() != 0 || due_results.size() != 0) @(posedge clk);
    repeat (NODES + 16) @(posedge clk);
    if (bad == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  always @(posedge clk) begin : drive
    bit fire;
    fire = start && !busy;
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
    end else begin
      if (fire) begin
        void'(cmd_backlog.pop_front());
        due_results.push_back(backlog_results.pop_front());
        sent++;
      end
      if (start && !fire) begin
        // hold until the transfer
      end else if (gap_left != 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (cmd_backlog.size() == 0) begin
        start <= 1'b0;
      end else if (cmd_backlog.size() > CALM_TAIL && (sent / 50) % 3 != 2 &&
                   $urandom_range(0, 3) == 0) begin
        start <= 1'b0;
        gap_left <= $urandom_range(0, 15);
      end else begin
        start <= 1'b1;
        request <= cmd_backlog[0];
      end
    end
  end

  always @(posedge clk) begin : watch
    result_t want;
    if (!rst && done) begin
      if (due_results.size() == 0) begin
        bad++;
        if (bad <= 10) $display("unexpected result: status %0d slot %0d value %0d next %0d",
                                result.status, result.slot, result.slot_value, result.slot_next);
      end else begin
        want = due_results.pop_front();
        if (result !== want) begin
          bad++;
          if (bad <= 10) begin
            $display("mismatch: expected status %0d slot %0d value %0d next %0d",
                     want.status, want.slot, want.slot_value, want.slot_next);
            $display("          got      status %0d slot %0d value %0d next %0d",
                     result.status, result.slot, result.slot_value, result.slot_next);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet <= 0;
    end else if (quiet >= WATCH_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

endmodule

[array_linked_list_engine_core.f]
+incdir+design
design/alle_pkg.sv
design/alle_ram.sv
design/alle_ctrl.sv
design/array_linked_list_engine_core.sv
dv/array_linked_list_engine_core_tb.sv
